// File: rtl/glc_pkg.sv
// Shared constants, types and codes for the grid cell locator.
`timescale 1ns / 1ps

package glc_pkg;

   localparam int MAX_CELLS = 4096;
   localparam int COORD_W   = 32;
   localparam int IDX_W     = 12;
   localparam int CNT_W     = 13;
   localparam int OUT_W     = 14;
   localparam int PADDR_W   = 3;

   localparam logic [CNT_W-1:0] CELL_COUNT_RESET = CNT_W'(1);
   localparam logic [CNT_W-1:0] CELL_COUNT_MAX   = CNT_W'(MAX_CELLS);

   // item codes
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // register index, taken from paddr[2]
   localparam logic CSR_CELL_COUNT = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_PROBE,
      ST_CENTER,
      ST_DONE
   } glc_state_type;

   typedef struct packed {
      logic                      en;
      logic [IDX_W-1:0]          addr;
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] right;
   } glc_wr_type;

   typedef struct packed {
      logic                    idle;
      logic                    done;
      logic signed [OUT_W-1:0] cell_index;
   } glc_status_type;

endpackage

// File: rtl/glc_edge_mem.sv
// Edge table: left and right edges per cell, one write port, one registered read port.
`timescale 1ns / 1ps

module glc_edge_mem (
   input  logic                             clock,
   input  glc_pkg::glc_wr_type              wr,
   input  logic [glc_pkg::IDX_W-1:0]        rd_addr,
   output logic signed [glc_pkg::COORD_W-1:0] rd_left,
   output logic signed [glc_pkg::COORD_W-1:0] rd_right
);

   logic [2*glc_pkg::COORD_W-1:0] edge_mem_ff [glc_pkg::MAX_CELLS];
   logic [2*glc_pkg::COORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         edge_mem_ff[wr.addr] <= {wr.left, wr.right};
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= edge_mem_ff[rd_addr];
   end

   assign rd_left  = $signed(rd_data_ff[2*glc_pkg::COORD_W-1:glc_pkg::COORD_W]);
   assign rd_right = $signed(rd_data_ff[glc_pkg::COORD_W-1:0]);

endmodule

// File: rtl/glc_search.sv
// Search sequencer: range checks, one probe per cycle, final center test.
`timescale 1ns / 1ps

module glc_search (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [glc_pkg::COORD_W-1:0] target,
   input  logic [glc_pkg::CNT_W-1:0]          cell_count,
   input  logic                               take,
   input  logic signed [glc_pkg::COORD_W-1:0] rd_left,
   input  logic signed [glc_pkg::COORD_W-1:0] rd_right,
   output logic [glc_pkg::IDX_W-1:0]          rd_addr,
   output glc_pkg::glc_status_type            status
);

   localparam int IW = glc_pkg::IDX_W;
   localparam int OW = glc_pkg::OUT_W;
   localparam int CW = glc_pkg::COORD_W;

   glc_pkg::glc_state_type state_ff, state_in;

   logic signed [CW-1:0] t_ff;
   logic [glc_pkg::CNT_W-1:0] n_ff, n_in;
   logic signed [OW-1:0] low_ff, low_in, high_ff, high_in, result_ff, result_in;
   logic [IW-1:0] mid_ff, mid_in;

   logic [IW-1:0] last_idx;
   logic below_first, above_last;
   logic probe_lt, probe_eq;
   logic signed [OW-1:0] low_nx, high_nx, mid_sum;
   logic probe_more;
   logic signed [CW+1:0] center_sum, twice_t;
   logic above_center;

   function automatic logic target_lt(input logic signed [CW-1:0] a,
                                      input logic signed [CW-1:0] b);
      target_lt = a < b;
   endfunction

   // clamp the count to 1..MAX_CELLS
   always_comb begin
      if (cell_count == '0) begin
         n_in = glc_pkg::CNT_W'(1);
      end else if (cell_count > glc_pkg::CELL_COUNT_MAX) begin
         n_in = glc_pkg::CELL_COUNT_MAX;
      end else begin
         n_in = cell_count;
      end
   end

   // compare decisions on the word read in the previous cycle
   always_comb begin
      last_idx    = IW'(n_ff - glc_pkg::CNT_W'(1));
      below_first = target_lt(t_ff, rd_left);
      above_last  = target_lt(rd_left, t_ff);
      probe_lt    = rd_left < t_ff;
      probe_eq    = rd_left == t_ff;
      if (probe_lt) begin
         low_nx  = $signed({2'b00, mid_ff}) + OW'(1);
         high_nx = high_ff;
      end else begin
         low_nx  = low_ff;
         high_nx = $signed({2'b00, mid_ff}) - OW'(1);
      end
      probe_more   = low_nx <= high_nx;
      mid_sum      = low_nx + high_nx;
      center_sum   = $signed({{2{rd_left[CW-1]}}, rd_left})
                   + $signed({{2{rd_right[CW-1]}}, rd_right});
      twice_t      = $signed({t_ff[CW-1], t_ff, 1'b0});
      above_center = twice_t > center_sum;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         glc_pkg::ST_IDLE: begin
            if (start) state_in = glc_pkg::ST_FIRST;
         end
         glc_pkg::ST_FIRST: begin
            state_in = below_first ? glc_pkg::ST_DONE : glc_pkg::ST_LAST;
         end
         glc_pkg::ST_LAST: begin
            state_in = above_last ? glc_pkg::ST_DONE : glc_pkg::ST_PROBE;
         end
         glc_pkg::ST_PROBE: begin
            if (probe_eq) begin
               state_in = glc_pkg::ST_DONE;
            end else if (!probe_more) begin
               state_in = (high_nx < 0) ? glc_pkg::ST_DONE : glc_pkg::ST_CENTER;
            end
         end
         glc_pkg::ST_CENTER: begin
            state_in = glc_pkg::ST_DONE;
         end
         glc_pkg::ST_DONE: begin
            if (take) state_in = glc_pkg::ST_IDLE;
         end
         default: state_in = glc_pkg::ST_IDLE;
      endcase
   end

   // read address and working registers
   always_comb begin
      rd_addr   = '0;
      low_in    = low_ff;
      high_in   = high_ff;
      mid_in    = mid_ff;
      result_in = result_ff;
      case (state_ff)
         glc_pkg::ST_FIRST: begin
            rd_addr = last_idx;
            if (below_first) result_in = -OW'(1);
         end
         glc_pkg::ST_LAST: begin
            low_in  = '0;
            high_in = $signed({2'b00, last_idx});
            mid_in  = last_idx >> 1;
            rd_addr = last_idx >> 1;
            if (above_last) result_in = $signed({1'b0, n_ff});
         end
         glc_pkg::ST_PROBE: begin
            low_in  = low_nx;
            high_in = high_nx;
            if (probe_eq) begin
               result_in = $signed({2'b00, mid_ff}) - OW'(1);
            end else if (probe_more) begin
               mid_in  = mid_sum[IW:1];
               rd_addr = mid_sum[IW:1];
            end else begin
               rd_addr   = high_nx[IW-1:0];
               result_in = -OW'(1);
            end
         end
         glc_pkg::ST_CENTER: begin
            result_in = above_center ? high_ff : high_ff - OW'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= glc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == glc_pkg::ST_IDLE && start) begin
         t_ff <= target;
         n_ff <= n_in;
      end
      low_ff    <= low_in;
      high_ff   <= high_in;
      mid_ff    <= mid_in;
      result_ff <= result_in;
   end

   assign status.idle       = state_ff == glc_pkg::ST_IDLE;
   assign status.done       = state_ff == glc_pkg::ST_DONE;
   assign status.cell_index = result_ff;

endmodule

// File: rtl/grid_cell_locator.sv
// Top level: request/response channels, cell_count register, edge table and search.
//
//   channel   dir   beat contents
//   req_*     in    command, entry_index, left_edge, right_edge, target
//   rsp_*     out   cell_index (one beat per query, none per load)
//   csr       in    APB register cell_count at byte address 0
//
// A load writes the edge table at its accept edge. A query tests the first edge and,
// unless below it, the last, then probes by binary search, with a center test when
// no edge matches: the single read port of the edge table gives one left edge per
// cycle. The result moves into the rsp register as soon as that register is free.
// req_stall stays high while a query is in flight or its result cannot yet
// move into the rsp register; a waiting rsp beat does not block the next item.
// Synchronous reset sets cell_count to 1 and empties both channels.
`timescale 1ns / 1ps

module grid_cell_locator (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic [glc_pkg::IDX_W-1:0]           req_entry_index,
   input  logic signed [glc_pkg::COORD_W-1:0]  req_left_edge,
   input  logic signed [glc_pkg::COORD_W-1:0]  req_right_edge,
   input  logic signed [glc_pkg::COORD_W-1:0]  req_target,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [glc_pkg::OUT_W-1:0]    rsp_cell_index,

   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [glc_pkg::PADDR_W-1:0]         paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   logic [glc_pkg::CNT_W-1:0] cnt_ff;
   logic rsp_valid_ff;
   logic signed [glc_pkg::OUT_W-1:0] rsp_cell_index_ff;

   glc_pkg::glc_wr_type     wr;
   glc_pkg::glc_status_type status;
   logic [glc_pkg::IDX_W-1:0] rd_addr;
   logic signed [glc_pkg::COORD_W-1:0] rd_left, rd_right;
   logic req_beat, query_start, result_move;

   assign pready    = 1'b1;
   assign req_stall = !status.idle;
   assign req_beat  = req_valid && !req_stall;
   assign query_start = req_beat && req_command == glc_pkg::CMD_QUERY;
   assign result_move = status.done && (!rsp_valid_ff || !rsp_stall);

   assign wr.en    = req_beat && req_command == glc_pkg::CMD_LOAD;
   assign wr.addr  = req_entry_index;
   assign wr.left  = req_left_edge;
   assign wr.right = req_right_edge;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= glc_pkg::CELL_COUNT_RESET;
      end else if (psel && penable && pwrite && paddr[2] == glc_pkg::CSR_CELL_COUNT) begin
         cnt_ff <= pwdata[glc_pkg::CNT_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == glc_pkg::CSR_CELL_COUNT) begin
         prdata = {{(32 - glc_pkg::CNT_W){1'b0}}, cnt_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result_move) begin
         rsp_cell_index_ff <= status.cell_index;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_index = rsp_cell_index_ff;

   glc_edge_mem u_mem (
      .clock    (clock),
      .wr       (wr),
      .rd_addr  (rd_addr),
      .rd_left  (rd_left),
      .rd_right (rd_right)
   );

   glc_search u_search (
      .clock      (clock),
      .reset      (reset),
      .start      (query_start),
      .target     (req_target),
      .cell_count (cnt_ff),
      .take       (result_move),
      .rd_left    (rd_left),
      .rd_right   (rd_right),
      .rd_addr    (rd_addr),
      .status     (status)
   );

`ifndef NO_ASSERTIONS
   // a query holds off the next item
   a_query_blocks: assert property (@(posedge clock) disable iff (reset)
      query_start |=> req_stall)
      else $error("query accepted but next cycle not stalled");

   // table writes only while no search runs
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> status.idle)
      else $error("edge table written during a search");

   a_idle_done: assert property (@(posedge clock) disable iff (reset)
      !(status.idle && status.done))
      else $error("search idle and done at once");

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cell_index >= -14'sd1 && rsp_cell_index <= 14'sd4096))
      else $error("cell_index out of range");
`endif

endmodule

// File: bench/grid_cell_locator_test.sv
// Self-checking bench for grid_cell_locator: edge table loads, cell queries, cell_count register.
`timescale 1ns / 1ps

module grid_cell_locator_test;

   localparam int MAX_CELLS = glc_pkg::MAX_CELLS;
   localparam int COORD_W   = glc_pkg::COORD_W;
   localparam int IDX_W     = glc_pkg::IDX_W;
   localparam int CNT_W     = glc_pkg::CNT_W;
   localparam int OUT_W     = glc_pkg::OUT_W;
   localparam int PADDR_W   = glc_pkg::PADDR_W;
   localparam logic CMD_LOAD       = glc_pkg::CMD_LOAD;
   localparam logic CMD_QUERY      = glc_pkg::CMD_QUERY;
   localparam logic CSR_CELL_COUNT = glc_pkg::CSR_CELL_COUNT;
   localparam logic [CNT_W-1:0] CELL_COUNT_RESET = glc_pkg::CELL_COUNT_RESET;
   localparam logic [CNT_W-1:0] CELL_COUNT_MAX   = glc_pkg::CELL_COUNT_MAX;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_BEATS = 1900;
   localparam logic [PADDR_W-1:0] CELL_COUNT_ADDR = {CSR_CELL_COUNT, 2'b00};

   typedef enum logic { ROW_ITEM, ROW_CSR } row_kind_type;

   // directed step; a CSR row carries the register value in target
   typedef struct packed {
      row_kind_type              kind;
      logic                      cmd;
      logic [IDX_W-1:0]          idx;
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] right;
      logic signed [COORD_W-1:0] target;
      logic                      typed;
      logic signed [OUT_W-1:0]   want;
   } stim_row_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_command;
   logic [IDX_W-1:0]          req_entry_index;
   logic signed [COORD_W-1:0] req_left_edge;
   logic signed [COORD_W-1:0] req_right_edge;
   logic signed [COORD_W-1:0] req_target;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic signed [OUT_W-1:0]   rsp_cell_index;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [PADDR_W-1:0]        paddr;
   logic [31:0]               pwdata;
   logic [31:0]               prdata;
   logic                      pready;

   // local copy of the block's state
   logic signed [COORD_W-1:0] left_tab [MAX_CELLS];
   logic signed [COORD_W-1:0] right_tab [MAX_CELLS];
   bit                        entry_written [MAX_CELLS];
   logic [CNT_W-1:0]          cell_count_q;
   int                        missing_entry;

   logic signed [OUT_W-1:0]   due_cell_index [$];
   stim_row_type              plan [$];
   int                        mismatch_count;
   int                        csr_mismatch_count;
   int                        beats_sent;
   int                        cycle_count;
   logic                      steady;
   longint                    layout_base;
   longint                    layout_step;

   assign steady = (cycle_count >= 3000) && (cycle_count < 9000);

   grid_cell_locator i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_entry_index (req_entry_index),
      .req_left_edge   (req_left_edge),
      .req_right_edge  (req_right_edge),
      .req_target      (req_target),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cell_index  (rsp_cell_index),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // notes the first entry a search would read before it was ever loaded
   function automatic bit seen(input int i);
      if (!entry_written[i] && missing_entry < 0) missing_entry = i;
      return entry_written[i];
   endfunction

   function automatic logic signed [OUT_W-1:0] locate_cell(input logic signed [COORD_W-1:0] t);
      int n;
      int lo;
      int hi;
      int mid;
      n = int'(cell_count_q);
      if (n < 1) n = 1;
      if (n > MAX_CELLS) n = MAX_CELLS;
      lo = 0;
      hi = n - 1;
      if (!seen(0)) return '0;
      if (t < left_tab[0]) return -14'sd1;
      if (!seen(n - 1)) return '0;
      if (t > left_tab[n - 1]) return OUT_W'(n);
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (!seen(mid)) return '0;
         if (left_tab[mid] < t) lo = mid + 1;
         else if (left_tab[mid] > t) hi = mid - 1;
         else return OUT_W'(mid - 1);
      end
      if (hi < 0) return -14'sd1;
      if (!seen(hi)) return '0;
      // center test without rounding: 2*t against left + right
      if (2 * longint'(t) > longint'(left_tab[hi]) + longint'(right_tab[hi]))
         return OUT_W'(hi);
      return OUT_W'(hi - 1);
   endfunction

   function automatic logic signed [COORD_W-1:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic logic signed [COORD_W-1:0] q16(input int whole);
      return COORD_W'(whole) <<< 16;
   endfunction

   function automatic logic signed [COORD_W-1:0] left_at(input int i);
      return clamp32(layout_base + longint'(i) * layout_step);
   endfunction

   function automatic logic signed [COORD_W-1:0] right_for(input logic signed [COORD_W-1:0] l);
      if ($urandom_range(0, 99) < 15) return $urandom;
      return COORD_W'(longint'(l) + longint'($urandom_range(0, 32'(2 * layout_step))));
   endfunction

   function automatic void add_row(input row_kind_type kind, input logic cmd, input int idx,
                                   input logic signed [COORD_W-1:0] l,
                                   input logic signed [COORD_W-1:0] r,
                                   input logic signed [COORD_W-1:0] t,
                                   input logic typed, input int want);
      stim_row_type row;
      row.kind = kind;
      row.cmd = cmd;
      row.idx = IDX_W'(idx);
      row.left = l;
      row.right = r;
      row.target = t;
      row.typed = typed;
      row.want = OUT_W'(want);
      plan.push_back(row);
   endfunction

   // one beat on the request channel; the predictor sees it at its accept edge
   task automatic send_item(input logic cmd, input logic [IDX_W-1:0] idx,
                            input logic signed [COORD_W-1:0] l,
                            input logic signed [COORD_W-1:0] r,
                            input logic signed [COORD_W-1:0] t,
                            input logic typed, input logic signed [OUT_W-1:0] want);
      while (!steady && $urandom_range(0, 99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_entry_index <= idx;
      req_left_edge <= l;
      req_right_edge <= r;
      req_target <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      if (cmd == CMD_LOAD) begin
         left_tab[idx] = l;
         right_tab[idx] = r;
         entry_written[idx] = 1'b1;
      end else begin
         missing_entry = -1;
         due_cell_index.push_back(typed ? want : locate_cell(t));
      end
   endtask

   task automatic csr_access(input logic wr, input logic [CNT_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= CELL_COUNT_ADDR;
      pwdata <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (!wr && prdata !== 32'(cell_count_q)) begin
         $error("cell_count readback: expected %0d, got %0d", cell_count_q, prdata);
         csr_mismatch_count++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // only touched with nothing in flight; loads give no beat, so allow them to settle
   task automatic set_cell_count(input logic [CNT_W-1:0] value);
      req_valid <= 1'b0;
      while (due_cell_index.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_access(1'b1, value);
      cell_count_q = value;
      @(posedge clock);
      csr_access(1'b0, '0);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      logic signed [OUT_W-1:0] want;
      rsp_stall <= !steady && ($urandom_range(0, 99) < 19);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_cell_index.size() == 0) begin
            $error("cell_index: no beat expected, got %0d", rsp_cell_index);
            mismatch_count++;
         end else begin
            want = due_cell_index.pop_front();
            if (rsp_cell_index !== want) begin
               $error("cell_index: expected %0d, got %0d", want, rsp_cell_index);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int phase;
      int n_eff;
      int roll;
      int k;
      logic [CNT_W-1:0] count_val;
      logic signed [COORD_W-1:0] tgt;
      logic signed [COORD_W-1:0] lv;
      longint span;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_command <= CMD_LOAD;
      req_entry_index <= '0;
      req_left_edge <= '0;
      req_right_edge <= '0;
      req_target <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      csr_mismatch_count = 0;
      beats_sent = 0;
      cell_count_q = CELL_COUNT_RESET;
      layout_base = 0;
      layout_step = 1;
      foreach (entry_written[i]) entry_written[i] = 1'b0;

      // single cell after reset, then extremes of the coordinate range
      add_row(ROW_ITEM, CMD_LOAD, 0, q16(1), q16(2), 0, 1'b0, 0);
      add_row(ROW_ITEM, CMD_QUERY, 0, 0, 0, 32'sh8000_0000, 1'b1, -1);
      add_row(ROW_ITEM, CMD_QUERY, 0, 0, 0, 32'sh7FFF_FFFF, 1'b1, 1);
      add_row(ROW_ITEM, CMD_QUERY, 0, 0, 0, q16(1), 1'b1, -1);
      add_row(ROW_ITEM, CMD_LOAD, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 1'b0, 0);
      add_row(ROW_ITEM, CMD_QUERY, 0, 0, 0, 32'sh8000_0000, 1'b1, -1);
      add_row(ROW_ITEM, CMD_QUERY, 0, 0, 0, 32'sh7FFF_FFFF, 1'b1, 1);
      // four sorted cells at 0, 10, 20, 30
      add_row(ROW_CSR, CMD_LOAD, 0, 0, 0, 4, 1'b0, 0);
      add_row(ROW_ITEM, CMD_LOAD, 0, q16(0), q16(10), 0, 1'b0, 0);
      add_row(ROW_ITEM, CMD_LOAD, 1, q16(10), q16(20), 0, 1'b0, 0);
      add_row(ROW_ITEM, CMD_LOAD, 2, q16(20), q16(30), 0, 1'b0, 0);
      add_row(ROW_ITEM, CMD_LOAD, 3, q16(30), q16(40), 0, 1'b0, 0);
      add_row(ROW_ITEM, CMD_LOAD, 4095, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'shFFFF_FFFF,
              1'b0, 0);
      add_row(ROW_ITEM, CMD_QUERY, 0, 0, 0, q16(20), 1'b1, 1);
      add_row(ROW_ITEM, CMD_QUERY, 0, 0, 0, q16(35), 1'b1, 4);
      add_row(ROW_ITEM, CMD_QUERY, 0, 0, 0, q16(16), 1'b0, 0);
      add_row(ROW_ITEM, CMD_QUERY, 0, 0, 0, q16(14), 1'b0, 0);
      add_row(ROW_ITEM, CMD_QUERY, 0, 0, 0, q16(15), 1'b0, 0);
      add_row(ROW_ITEM, CMD_QUERY, 0, 0, 0, 32'shFFFF_FFFF, 1'b1, -1);
      // zero count behaves as one cell
      add_row(ROW_CSR, CMD_LOAD, 0, 0, 0, 0, 1'b0, 0);
      add_row(ROW_ITEM, CMD_QUERY, 0, 0, 0, q16(5), 1'b1, 1);
      // break the ordering: search runs down to cell 0 and can end below it
      add_row(ROW_CSR, CMD_LOAD, 0, 0, 0, 4, 1'b0, 0);
      add_row(ROW_ITEM, CMD_LOAD, 1, q16(50), q16(60), 0, 1'b0, 0);
      add_row(ROW_ITEM, CMD_QUERY, 0, 0, 0, 32'sh0000_8000, 1'b0, 0);
      add_row(ROW_ITEM, CMD_QUERY, 0, 0, 0, q16(9), 1'b0, 0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      csr_access(1'b0, '0);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR)
            set_cell_count(CNT_W'(plan[i].target));
         else
            send_item(plan[i].cmd, plan[i].idx, plan[i].left, plan[i].right,
                      plan[i].target, plan[i].typed, plan[i].want);
      end

      phase = 0;
      while (phase < 6 || beats_sent < RANDOM_BEATS + plan.size()) begin
         case (phase)
            0: count_val = CELL_COUNT_MAX;
            1: count_val = '1;
            2: count_val = '0;
            3: count_val = CNT_W'(2);
            4: count_val = CNT_W'(1);
            default: begin
               roll = $urandom_range(0, 99);
               if (roll < 65) count_val = CNT_W'($urandom_range(2, 48));
               else if (roll < 75) count_val = CNT_W'($urandom_range(49, MAX_CELLS));
               else if (roll < 85) count_val = CNT_W'($urandom_range(MAX_CELLS + 1, 8191));
               else count_val = CNT_W'($urandom_range(0, 1));
            end
         endcase
         set_cell_count(count_val);
         n_eff = (count_val == 0) ? 1 : (count_val > MAX_CELLS) ? MAX_CELLS : count_val;

         // ascending left edges, spaced by a random step, placed anywhere in range
         layout_step = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(1, 4))
                                                    : longint'($urandom_range(1, 1 << 19));
         span = longint'(n_eff - 1) * layout_step;
         if ($urandom_range(0, 7) == 0)
            layout_base = -64'sd2147483648;
         else
            layout_base = -64'sd2147483648
                        + longint'($urandom_range(0, 32'(64'h0_FFFF_FFFF - span)));

         if (n_eff <= 64) begin
            for (int i = 0; i < n_eff; i++) begin
               lv = left_at(i);
               send_item(CMD_LOAD, IDX_W'(i), lv, right_for(lv), $urandom, 1'b0, '0);
            end
         end

         repeat (90) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
               send_item(CMD_LOAD, IDX_W'($urandom), $urandom, $urandom, $urandom, 1'b0, '0);
            end else begin
               k = $urandom_range(0, n_eff - 1);
               roll = $urandom_range(0, 99);
               if (roll < 30)
                  tgt = entry_written[k] ? left_tab[k] : left_at(k);
               else if (roll < 60)
                  tgt = clamp32(longint'(left_at(k))
                                + longint'($urandom_range(0, 32'(layout_step))));
               else if (roll < 70)
                  tgt = entry_written[k]
                      ? clamp32(((longint'(left_tab[k]) + longint'(right_tab[k])) >>> 1)
                                + longint'($urandom_range(0, 1)))
                      : left_at(k);
               else if (roll < 80)
                  tgt = $urandom_range(0, 1)
                      ? clamp32(longint'(left_at(0)) - longint'($urandom_range(1, 4)))
                      : clamp32(longint'(left_at(n_eff - 1)) + longint'($urandom_range(1, 4)));
               else
                  tgt = $urandom;
               // load every entry this search would read that has never been written
               forever begin
                  missing_entry = -1;
                  void'(locate_cell(tgt));
                  if (missing_entry < 0) break;
                  lv = left_at(missing_entry);
                  send_item(CMD_LOAD, IDX_W'(missing_entry), lv, right_for(lv), $urandom,
                            1'b0, '0);
               end
               send_item(CMD_QUERY, IDX_W'($urandom), $urandom, $urandom, tgt, 1'b0, '0);
            end
         end
         phase++;
      end

      req_valid <= 1'b0;
      while (due_cell_index.size() != 0) @(posedge clock);
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && csr_mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
